// File: design/hrf_pkg.sv
package hrf_pkg;

	localparam int LENGTH_BITS = 31;
	localparam int VALUE_BITS = LENGTH_BITS + 4;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	localparam logic [2:0] PH_STATUS = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;

	localparam logic [1:0] BLANK_EMPTY = 2'd0;
	localparam logic [1:0] BLANK_CR    = 2'd1;
	localparam logic [1:0] BLANK_TEXT  = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_STATUS    = 2'd1;
	localparam logic [1:0] ERR_NO_LENGTH = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_1  = 8'h31;
	localparam logic [7:0] CHAR_9  = 8'h39;

	localparam logic [4:0] STATUS_LEN  = 5'd15;
	localparam logic [4:0] PREFIX_LEN  = 5'd16;
	localparam logic [4:0] VERSION_POS = 5'd7;
	localparam logic [4:0] POS_MAX     = 5'd31;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_response;
	} in_t;

	typedef struct packed {
		logic                   payload_valid;
		logic [7:0]             payload_byte;
		logic                   response_done;
		logic [1:0]             error_code;
		logic                   header_complete;
		logic [LENGTH_BITS-1:0] body_length;
	} out_t;

	// "HTTP/1.1 200 OK"
	function automatic logic [7:0] status_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h48;
			4'd1: c = 8'h54;
			4'd2: c = 8'h54;
			4'd3: c = 8'h50;
			4'd4: c = 8'h2f;
			4'd5: c = 8'h31;
			4'd6: c = 8'h2e;
			4'd7: c = 8'h31;
			4'd8: c = 8'h20;
			4'd9: c = 8'h32;
			4'd10: c = 8'h30;
			4'd11: c = 8'h30;
			4'd12: c = 8'h20;
			4'd13: c = 8'h4f;
			4'd14: c = 8'h4b;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "Content-Length: "
	function automatic logic [7:0] prefix_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h43;
			4'd1: c = 8'h6f;
			4'd2: c = 8'h6e;
			4'd3: c = 8'h74;
			4'd4: c = 8'h65;
			4'd5: c = 8'h6e;
			4'd6: c = 8'h74;
			4'd7: c = 8'h2d;
			4'd8: c = 8'h4c;
			4'd9: c = 8'h65;
			4'd10: c = 8'h6e;
			4'd11: c = 8'h67;
			4'd12: c = 8'h74;
			4'd13: c = 8'h68;
			4'd14: c = 8'h3a;
			4'd15: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: design/http_response_framer.sv
// HTTP/1.x response framer.
// rx channel: one response byte per transaction (rx_item), with start_response
// set on the first byte of a new response to clear the parser.
// frm channel: exactly one result per rx transaction (frm_item): body bytes
// with payload_valid, header_complete with the parsed body_length, and
// response_done with error_code on the last body byte, a zero length or an
// error. After that, results are all zero until the next start_response.
// Results are registered: frm_item is driven from the output register.
// Throughput: one byte per cycle while rx_ready is high; the parser updates
// its state in the same cycle the byte is accepted, and the result goes into
// a two-entry output buffer (output register plus skid register).
// Stalls: while frm_ready is low one more byte is taken into the skid
// register; rx_ready then drops until the receiver drains it.
// Reset (arst_n low): the parser returns to the status line phase and both
// output entries are emptied; rx_ready is high right after reset.
module http_response_framer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rx_valid,
	output logic          rx_ready,
	input  hrf_pkg::in_t  rx_item,
	output logic          frm_valid,
	input  logic          frm_ready,
	output hrf_pkg::out_t frm_item
);

	logic          accept;
	logic          take;
	hrf_pkg::out_t res;
	hrf_pkg::out_t out_q;
	hrf_pkg::out_t skid_q;
	logic          out_vld_q;
	logic          skid_vld_q;

	assign rx_ready  = !skid_vld_q;
	assign accept    = rx_valid && rx_ready;
	assign take      = out_vld_q && frm_ready;
	assign frm_valid = out_vld_q;
	assign frm_item  = out_q;

	hrf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (rx_item),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				out_vld_q  <= skid_vld_q || accept;
				skid_vld_q <= 1'b0;
			end else if (accept) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

// File: design/hrf_parser.sv
module hrf_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  hrf_pkg::in_t item,
	output hrf_pkg::out_t res
);

	logic [2:0]                      phase_q, phase_d;
	logic [4:0]                      pos_q, pos_d;
	logic                            stat_ok_q, stat_ok_d;
	logic                            pfx_ok_q, pfx_ok_d;
	logic [1:0]                      blank_q, blank_d;
	logic [hrf_pkg::LENGTH_BITS-1:0] dval_q, dval_d;
	logic                            dok_q, dok_d;
	logic                            pcr_q, pcr_d;
	logic                            lseen_q, lseen_d;
	logic [hrf_pkg::LENGTH_BITS-1:0] lval_q, lval_d;
	logic [hrf_pkg::LENGTH_BITS-1:0] bcnt_q, bcnt_d;

	always_comb begin
		logic [7:0]                      b;
		logic [7:0]                      want;
		logic                            ok;
		logic [hrf_pkg::VALUE_BITS-1:0]  wide;
		logic [hrf_pkg::VALUE_BITS-1:0]  v;
		phase_d = phase_q;
		pos_d   = pos_q;
		stat_ok_d = stat_ok_q;
		pfx_ok_d  = pfx_ok_q;
		blank_d = blank_q;
		dval_d  = dval_q;
		dok_d   = dok_q;
		pcr_d   = pcr_q;
		lseen_d = lseen_q;
		lval_d  = lval_q;
		bcnt_d  = bcnt_q;
		res     = '0;
		b       = item.data_byte;
		want    = 8'h00;
		ok      = 1'b1;
		wide    = {{(hrf_pkg::VALUE_BITS-hrf_pkg::LENGTH_BITS){1'b0}}, dval_q};
		v       = '0;

		if (item.start_response) begin
			phase_d = hrf_pkg::PH_STATUS;
			pos_d = '0;
			stat_ok_d = 1'b1;
			pfx_ok_d = 1'b1;
			blank_d = hrf_pkg::BLANK_EMPTY;
			dval_d = '0;
			dok_d = 1'b1;
			pcr_d = 1'b0;
			lseen_d = 1'b0;
			lval_d = '0;
			bcnt_d = '0;
		end
		wide = {{(hrf_pkg::VALUE_BITS-hrf_pkg::LENGTH_BITS){1'b0}}, dval_d};

		case (phase_d)
			hrf_pkg::PH_STATUS: begin
				if (b == hrf_pkg::CHAR_LF) begin
					if (!(stat_ok_d && pos_d >= hrf_pkg::STATUS_LEN)) begin
						res.error_code = hrf_pkg::ERR_STATUS;
						res.response_done = 1'b1;
						phase_d = hrf_pkg::PH_DONE;
					end else begin
						phase_d = hrf_pkg::PH_HEADER;
					end
					pos_d = '0;
					stat_ok_d = 1'b1;
					pfx_ok_d = 1'b1;
					blank_d = hrf_pkg::BLANK_EMPTY;
					dval_d = '0;
					dok_d = 1'b1;
					pcr_d = 1'b0;
				end else begin
					if (pos_d < hrf_pkg::STATUS_LEN) begin
						want = hrf_pkg::status_char(pos_d[3:0]);
						// version digit may be 0 or 1
						if (pos_d == hrf_pkg::VERSION_POS)
							ok = (b == hrf_pkg::CHAR_1) || (b == hrf_pkg::CHAR_0);
						else
							ok = (b == want);
						if (!ok)
							stat_ok_d = 1'b0;
					end
					if (pos_d < hrf_pkg::POS_MAX)
						pos_d = pos_d + 5'd1;
				end
			end
			hrf_pkg::PH_HEADER: begin
				if (b == hrf_pkg::CHAR_LF) begin
					if (blank_d != hrf_pkg::BLANK_TEXT) begin
						res.header_complete = 1'b1;
						if (!lseen_d) begin
							res.error_code = hrf_pkg::ERR_NO_LENGTH;
							res.response_done = 1'b1;
							phase_d = hrf_pkg::PH_DONE;
						end else begin
							res.body_length = lval_d;
							bcnt_d = '0;
							if (lval_d == '0) begin
								res.response_done = 1'b1;
								phase_d = hrf_pkg::PH_DONE;
							end else begin
								phase_d = hrf_pkg::PH_BODY;
							end
						end
					end else if (pfx_ok_d && pos_d >= hrf_pkg::PREFIX_LEN) begin
						lseen_d = 1'b1;
						lval_d = dok_d ? dval_d : '0;
					end
					pos_d = '0;
					stat_ok_d = 1'b1;
					pfx_ok_d = 1'b1;
					blank_d = hrf_pkg::BLANK_EMPTY;
					dval_d = '0;
					dok_d = 1'b1;
					pcr_d = 1'b0;
				end else begin
					if (b == hrf_pkg::CHAR_CR && blank_d == hrf_pkg::BLANK_EMPTY)
						blank_d = hrf_pkg::BLANK_CR;
					else
						blank_d = hrf_pkg::BLANK_TEXT;
					if (pos_d < hrf_pkg::PREFIX_LEN) begin
						if (b != hrf_pkg::prefix_char(pos_d[3:0]))
							pfx_ok_d = 1'b0;
					end else if (pfx_ok_d) begin
						// a CR only counts if the newline follows right after it
						if (pcr_d)
							dok_d = 1'b0;
						pcr_d = 1'b0;
						if (b == hrf_pkg::CHAR_CR) begin
							pcr_d = 1'b1;
						end else if (b >= hrf_pkg::CHAR_0 && b <= hrf_pkg::CHAR_9) begin
							if (dok_d) begin
								v = (wide << 3) + (wide << 1)
									+ {{(hrf_pkg::VALUE_BITS-4){1'b0}}, b[3:0]};
								if (v[hrf_pkg::VALUE_BITS-1:hrf_pkg::LENGTH_BITS] != '0) begin
									dok_d = 1'b0;
									dval_d = '0;
								end else begin
									dval_d = v[hrf_pkg::LENGTH_BITS-1:0];
								end
							end
						end else begin
							dok_d = 1'b0;
						end
					end
					if (pos_d < hrf_pkg::POS_MAX)
						pos_d = pos_d + 5'd1;
				end
			end
			hrf_pkg::PH_BODY: begin
				res.payload_valid = 1'b1;
				res.payload_byte = b;
				bcnt_d = bcnt_d + {{(hrf_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
				if (bcnt_d >= lval_d) begin
					res.response_done = 1'b1;
					phase_d = hrf_pkg::PH_DONE;
				end
			end
			default: begin
				// finished, and unused codes: bytes are dropped
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hrf_pkg::PH_STATUS;
			pos_q     <= '0;
			stat_ok_q <= 1'b1;
			pfx_ok_q  <= 1'b1;
			blank_q   <= hrf_pkg::BLANK_EMPTY;
			dval_q    <= '0;
			dok_q     <= 1'b1;
			pcr_q     <= 1'b0;
			lseen_q   <= 1'b0;
			lval_q    <= '0;
			bcnt_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			stat_ok_q <= stat_ok_d;
			pfx_ok_q  <= pfx_ok_d;
			blank_q   <= blank_d;
			dval_q    <= dval_d;
			dok_q     <= dok_d;
			pcr_q     <= pcr_d;
			lseen_q   <= lseen_d;
			lval_q    <= lval_d;
			bcnt_q    <= bcnt_d;
		end
	end

endmodule

// File: design/hrf_checker.sv
module hrf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rx_valid,
	input logic          rx_ready,
	input hrf_pkg::in_t  rx_item,
	input logic          frm_valid,
	input logic          frm_ready,
	input hrf_pkg::out_t frm_item
);

	// a stalled result transaction holds its payload
	a_frm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && !frm_ready |=> frm_valid && $stable(frm_item))
		else $error("result changed while stalled");

	// back-pressure on the input only when the output side is full
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> frm_valid)
		else $error("rx_ready low with empty output");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_item.error_code != hrf_pkg::ERR_NONE |->
			frm_item.response_done && !frm_item.payload_valid
			&& frm_item.error_code <= hrf_pkg::ERR_NO_LENGTH)
		else $error("error without done");

	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_item.payload_valid |->
			!frm_item.header_complete && frm_item.error_code == hrf_pkg::ERR_NONE)
		else $error("body byte mixed with header result");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_item.header_complete && frm_item.body_length == '0 |->
			frm_item.response_done)
		else $error("zero length header end not marked done");

endmodule

bind http_response_framer hrf_checker u_hrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx_valid),
	.rx_ready  (rx_ready),
	.rx_item   (rx_item),
	.frm_valid (frm_valid),
	.frm_ready (frm_ready),
	.frm_item  (frm_item)
);
